>>> sv/asc_pkg.sv
// shared types, codes and helpers for the box slide collision block
`default_nettype none

package asc_pkg;

   // fixed-point format and default obstacle gap (0.0005 rounded)
   localparam int FRAC_BITS    = 16;
   localparam int MARGIN_W     = 16;
   localparam logic [MARGIN_W-1:0] MARGIN_RESET =
      MARGIN_W'((((64'd1 << FRAC_BITS) * 64'd5) + 64'd5000) / 64'd10000);

   // result queue depth
   localparam int Q_DEPTH = 4;
   localparam int PTR_W   = $clog2(Q_DEPTH);
   localparam int CNT_W   = $clog2(Q_DEPTH + 1);

   // packed word widths on the streams
   localparam int REQ_DATA_W = 208;
   localparam int RSP_DATA_W = 104;

   // command codes
   localparam logic CMD_BEGIN = 1'b0;
   localparam logic CMD_BOX   = 1'b1;

   // result kinds
   localparam logic KIND_EVENT = 1'b0;
   localparam logic KIND_FINAL = 1'b1;

   // normal component codes
   localparam logic signed [1:0] NRM_NEG  = 2'sb11;
   localparam logic signed [1:0] NRM_ZERO = 2'sb00;
   localparam logic signed [1:0] NRM_POS  = 2'sb01;

   // saturated extremes stand for unbounded limits
   localparam logic signed [31:0] POS_EXT = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] NEG_EXT = 32'sh8000_0000;

   typedef logic signed [33:0] wide_type;

   typedef struct packed {
      logic                cmd;
      logic [15:0]         ent_id;
      logic signed [31:0]  box_x;
      logic signed [31:0]  box_y;
      logic [30:0]         box_w;
      logic [30:0]         box_h;
      logic signed [31:0]  move_dx;
      logic signed [31:0]  move_dy;
      logic                has_motion;
      logic                last_box;
   } item_type;

   typedef struct packed {
      logic [15:0]         mover_ident;
      logic signed [31:0]  cur_x;
      logic signed [31:0]  cur_y;
      logic [30:0]         cur_w;
      logic [30:0]         cur_h;
      logic signed [31:0]  want_x;
      logic signed [31:0]  want_y;
      logic signed [31:0]  disp_x;
      logic signed [31:0]  disp_y;
      logic signed [31:0]  max_x;
      logic signed [31:0]  min_x;
      logic signed [31:0]  max_y;
      logic signed [31:0]  min_y;
      logic                motion;
   } slide_type;

   typedef struct packed {
      logic                out_kind;
      logic [15:0]         mover_id;
      logic [15:0]         other_id;
      logic signed [1:0]   normal_x;
      logic signed [1:0]   normal_y;
      logic signed [31:0]  new_x;
      logic signed [31:0]  new_y;
      logic                fall_start;
      logic                run_end;
   } result_type;

   // sign-extend a coordinate
   function automatic wide_type ext_s(input logic signed [31:0] v);
      ext_s = wide_type'(v);
   endfunction

   // zero-extend a size
   function automatic wide_type ext_u(input logic [30:0] v);
      ext_u = signed'({3'b000, v});
   endfunction

   // clamp to the 32-bit signed range
   function automatic logic signed [31:0] sat32(input wide_type v);
      if (v > ext_s(POS_EXT)) begin
         sat32 = POS_EXT;
      end else if (v < ext_s(NEG_EXT)) begin
         sat32 = NEG_EXT;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

endpackage

`default_nettype wire

>>> sv/asc_core.sv
// per-item collision test, bound tightening and final clamp
`default_nettype none

module asc_core (
   input  wire asc_pkg::item_type          item,
   input  wire asc_pkg::slide_type         st,
   input  wire logic [asc_pkg::MARGIN_W-1:0] margin,
   output asc_pkg::slide_type         st_nxt,
   output logic                       ev_valid,
   output asc_pkg::result_type        ev,
   output logic                       fin_valid,
   output asc_pkg::result_type        fin
);

   asc_pkg::wide_type ax, ay, w, h, bx, by, bw, bh;
   asc_pkg::wide_type ol, orr, ot, ob, m;
   logic ovx, ovy;
   logic signed [1:0] nx, ny;

   assign ax  = asc_pkg::ext_s(st.want_x);
   assign ay  = asc_pkg::ext_s(st.want_y);
   assign w   = asc_pkg::ext_u(st.cur_w);
   assign h   = asc_pkg::ext_u(st.cur_h);
   assign bx  = asc_pkg::ext_s(item.box_x);
   assign by  = asc_pkg::ext_s(item.box_y);
   assign bw  = asc_pkg::ext_u(item.box_w);
   assign bh  = asc_pkg::ext_u(item.box_h);
   assign ol  = asc_pkg::ext_s(st.cur_x);
   assign orr = ol + w;
   assign ot  = asc_pkg::ext_s(st.cur_y);
   assign ob  = ot + h;
   assign m   = signed'({18'd0, margin});

   // strict overlap of wanted box and other box
   assign ovx = (ax < bx && ax + w > bx) || (bx < ax && bx + bw > ax);
   assign ovy = (ay < by && ay + h > by) || (by < ay && by + bh > ay);

   // crossing tests, above is the fallback
   always_comb begin
      nx = asc_pkg::NRM_ZERO;
      ny = asc_pkg::NRM_NEG;
      priority if (orr < bx && ax + w >= bx) begin
         nx = asc_pkg::NRM_NEG;
         ny = asc_pkg::NRM_ZERO;
      end else if (ob < by && ay + h >= by) begin
         nx = asc_pkg::NRM_ZERO;
         ny = asc_pkg::NRM_NEG;
      end else if (ol > bx + bw && ax <= bx + bw) begin
         nx = asc_pkg::NRM_POS;
         ny = asc_pkg::NRM_ZERO;
      end else if (ot > by + bh && ay <= by + bh) begin
         nx = asc_pkg::NRM_ZERO;
         ny = asc_pkg::NRM_POS;
      end else begin
         nx = asc_pkg::NRM_ZERO;
         ny = asc_pkg::NRM_NEG;
      end
   end

   // next slide state and collision event
   always_comb begin
      logic signed [31:0] v;
      v        = '0;
      st_nxt   = st;
      ev_valid = 1'b0;
      ev       = '0;
      if (item.cmd == asc_pkg::CMD_BEGIN) begin
         st_nxt.mover_ident = item.ent_id;
         st_nxt.cur_x  = item.box_x;
         st_nxt.cur_y  = item.box_y;
         st_nxt.cur_w  = item.box_w;
         st_nxt.cur_h  = item.box_h;
         st_nxt.disp_x = item.move_dx;
         st_nxt.disp_y = item.move_dy;
         st_nxt.want_x = asc_pkg::sat32(bx + asc_pkg::ext_s(item.move_dx));
         st_nxt.want_y = asc_pkg::sat32(by + asc_pkg::ext_s(item.move_dy));
         st_nxt.motion = item.has_motion;
         st_nxt.max_x  = asc_pkg::POS_EXT;
         st_nxt.min_x  = asc_pkg::NEG_EXT;
         st_nxt.max_y  = asc_pkg::POS_EXT;
         st_nxt.min_y  = asc_pkg::NEG_EXT;
      end else if (item.ent_id != st.mover_ident && ovx && ovy) begin
         ev_valid = 1'b1;
         // tighten the bound on the side that was hit
         if (nx == asc_pkg::NRM_NEG) begin
            v = asc_pkg::sat32(bx - w);
            if (v < st.max_x) st_nxt.max_x = v;
         end
         if (nx == asc_pkg::NRM_POS) begin
            v = asc_pkg::sat32(bx + bw);
            if (v > st.min_x) st_nxt.min_x = v;
         end
         if (ny == asc_pkg::NRM_NEG) begin
            v = asc_pkg::sat32(by - h);
            if (v < st.max_y) st_nxt.max_y = v;
         end
         if (ny == asc_pkg::NRM_POS) begin
            v = asc_pkg::sat32(by + bh);
            if (v > st.min_y) st_nxt.min_y = v;
         end
         ev.out_kind = asc_pkg::KIND_EVENT;
         ev.mover_id = st.mover_ident;
         ev.other_id = item.ent_id;
         ev.normal_x = nx;
         ev.normal_y = ny;
         ev.run_end  = !item.last_box;
      end
   end

   // final position: wanted move clamped to the bounds less the margin
   always_comb begin
      logic signed [31:0] lim, px, py;
      asc_pkg::wide_type  dy_moved;
      lim = '0;
      px  = st_nxt.cur_x;
      py  = st_nxt.cur_y;
      if (st_nxt.disp_x > 0) begin
         lim = (st_nxt.max_x == asc_pkg::POS_EXT) ? asc_pkg::POS_EXT
               : asc_pkg::sat32(asc_pkg::ext_s(st_nxt.max_x) - m);
         px  = (st_nxt.want_x < lim) ? st_nxt.want_x : lim;
      end else if (st_nxt.disp_x < 0) begin
         lim = (st_nxt.min_x == asc_pkg::NEG_EXT) ? asc_pkg::NEG_EXT
               : asc_pkg::sat32(asc_pkg::ext_s(st_nxt.min_x) + m);
         px  = (st_nxt.want_x > lim) ? st_nxt.want_x : lim;
      end
      if (st_nxt.disp_y > 0) begin
         lim = (st_nxt.max_y == asc_pkg::POS_EXT) ? asc_pkg::POS_EXT
               : asc_pkg::sat32(asc_pkg::ext_s(st_nxt.max_y) - m);
         py  = (st_nxt.want_y < lim) ? st_nxt.want_y : lim;
      end else if (st_nxt.disp_y < 0) begin
         lim = (st_nxt.min_y == asc_pkg::NEG_EXT) ? asc_pkg::NEG_EXT
               : asc_pkg::sat32(asc_pkg::ext_s(st_nxt.min_y) + m);
         py  = (st_nxt.want_y > lim) ? st_nxt.want_y : lim;
      end
      dy_moved = asc_pkg::ext_s(py) - asc_pkg::ext_s(st_nxt.cur_y);
      fin            = '0;
      fin.out_kind   = asc_pkg::KIND_FINAL;
      fin.mover_id   = st_nxt.mover_ident;
      fin.new_x      = px;
      fin.new_y      = py;
      fin.fall_start = st_nxt.motion && (st_nxt.disp_y > 0) && (dy_moved > m);
      fin.run_end    = 1'b1;
   end

   assign fin_valid = item.last_box;

endmodule

`default_nettype wire

>>> sv/aabb_slide_collision.sv
// top level: input register, slide state, result queue and margin register
//
//   channel  dir  width     tuser     tlast     contents
//   req_     in   208 data  cmd       last_box  begin or other box word
//   rsp_     out  104 data  out_kind  run_end   collision event or final position
//   csr_     in   16 data   -         -         margin write
//
// One word is taken per cycle while the queue has room; each is worked in one
// pass between the input register and a four-entry result queue.
// A word stays in the input register until the queue has room for two words.
// Reset (synchronous) empties the queue, opens all bounds, sets margin to 33.
// A stalled result side fills the queue and then holds req_tready low.
`default_nettype none

module aabb_slide_collision (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // ent_id, box_x, box_y, box_w, box_h, move_dx, move_dy, has_motion, pad
   input  wire logic [asc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                             req_tuser,   // cmd
   input  wire logic                             req_tlast,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // mover_id, other_id, normal_x, normal_y, new_x, new_y, fall_start, pad
   output logic [asc_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                  rsp_tuser,   // out_kind
   output logic                                  rsp_tlast,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic [asc_pkg::MARGIN_W-1:0]     csr_data,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready
);

   asc_pkg::item_type   req_item, in_ff;
   logic                in_valid_ff, in_valid_in;
   asc_pkg::slide_type  st_ff, st_nxt;
   logic [asc_pkg::MARGIN_W-1:0] margin_ff, margin_in;
   logic                ev_valid, fin_valid, fire, pop;
   asc_pkg::result_type ev, fin, first_res, second_res, head;
   logic [1:0]          push_n;
   asc_pkg::result_type queue [asc_pkg::Q_DEPTH];
   logic [asc_pkg::PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [asc_pkg::CNT_W-1:0] count_ff, count_in;

   // unpack the request word
   always_comb begin
      req_item.cmd        = req_tuser;
      req_item.ent_id     = req_tdata[15:0];
      req_item.box_x      = req_tdata[47:16];
      req_item.box_y      = req_tdata[79:48];
      req_item.box_w      = req_tdata[110:80];
      req_item.box_h      = req_tdata[141:111];
      req_item.move_dx    = req_tdata[173:142];
      req_item.move_dy    = req_tdata[205:174];
      req_item.has_motion = req_tdata[206];
      req_item.last_box   = req_tlast;
   end

   // item work
   asc_core u_core (
      .item      (in_ff),
      .st        (st_ff),
      .margin    (margin_ff),
      .st_nxt    (st_nxt),
      .ev_valid  (ev_valid),
      .ev        (ev),
      .fin_valid (fin_valid),
      .fin       (fin)
   );

   // flow control
   assign fire       = in_valid_ff &&
                       (count_ff <= asc_pkg::CNT_W'(asc_pkg::Q_DEPTH - 2));
   assign req_tready = !in_valid_ff || fire;
   assign pop        = rsp_tvalid && rsp_tready;
   assign csr_ready  = 1'b1;

   // order the results of one item
   always_comb begin
      push_n     = {1'b0, ev_valid} + {1'b0, fin_valid};
      first_res  = ev_valid ? ev : fin;
      second_res = fin;
   end

   // next-state logic for control
   always_comb begin
      in_valid_in = req_tready ? req_tvalid : in_valid_ff;
      margin_in   = csr_valid ? csr_data : margin_ff;
      head_in     = pop ? asc_pkg::PTR_W'(head_ff + 1'b1) : head_ff;
      tail_in     = fire ? asc_pkg::PTR_W'(tail_ff + asc_pkg::PTR_W'(push_n)) : tail_ff;
      count_in    = asc_pkg::CNT_W'(count_ff
                    + (fire ? asc_pkg::CNT_W'(push_n) : asc_pkg::CNT_W'(0))
                    - asc_pkg::CNT_W'(pop));
   end

   // control and slide state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         margin_ff   <= asc_pkg::MARGIN_RESET;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         st_ff       <= '{max_x: asc_pkg::POS_EXT, min_x: asc_pkg::NEG_EXT,
                          max_y: asc_pkg::POS_EXT, min_y: asc_pkg::NEG_EXT,
                          default: '0};
      end else begin
         in_valid_ff <= in_valid_in;
         margin_ff   <= margin_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         if (fire) st_ff <= st_nxt;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) in_ff <= req_item;
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (fire && push_n != 2'd0) queue[tail_ff] <= first_res;
      if (fire && push_n == 2'd2) queue[asc_pkg::PTR_W'(tail_ff + 1'b1)] <= second_res;
   end

   // result word
   assign head       = queue[head_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tuser  = head.out_kind;
   assign rsp_tlast  = head.run_end;
   assign rsp_tdata  = {3'b000, head.fall_start, head.new_y, head.new_x,
                        head.normal_y, head.normal_x, head.other_id, head.mover_id};

   // queue never overflows
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= asc_pkg::CNT_W'(asc_pkg::Q_DEPTH))
      else $error("result queue overflow");

   // a stalled input side always has a word waiting in the input register
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff)
      else $error("input stalled with empty input register");

   // a double result without a pop grows the queue by two
   a_double_push: assert property (@(posedge clock) disable iff (reset)
      (fire && push_n == 2'd2 && !pop) |=>
         count_ff == asc_pkg::CNT_W'($past(count_ff) + 2'd2))
      else $error("queue count wrong after double push");

   // upper bounds only shrink while boxes are worked
   a_bound_shrink: assert property (@(posedge clock) disable iff (reset)
      (fire && in_ff.cmd == asc_pkg::CMD_BOX) |=>
         (st_ff.max_x <= $past(st_ff.max_x) && st_ff.max_y <= $past(st_ff.max_y)))
      else $error("upper bound grew on a box word");

endmodule

`default_nettype wire

>>> dv/tb_aabb_slide_collision.sv
// testbench for the box slide collision block: directed table, random slides, scoreboard
`default_nettype none

module tb_aabb_slide_collision;

   localparam int  SETTLE_CYCLES = 8;
   localparam int  HOLD_CYCLES   = 400;
   localparam int  MODEL_CHECKED = -1;
   localparam int  SHOWN_MAX     = 10;

   // directed row: stimulus word plus any result typed in by hand
   typedef struct {
      asc_pkg::item_type   stim;
      int                  known;
      asc_pkg::result_type ans0;
      asc_pkg::result_type ans1;
   } drow_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic [asc_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                   req_tuser  = 1'b0;
   logic                   req_tlast  = 1'b0;
   logic                   req_tvalid = 1'b0;
   wire logic              req_tready;
   wire logic [asc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   wire logic              rsp_tuser;
   wire logic              rsp_tlast;
   wire logic              rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [asc_pkg::MARGIN_W-1:0] csr_data = '0;
   logic                   csr_valid  = 1'b0;
   wire logic              csr_ready;

   // slide state as the block should hold it
   logic [15:0]        mv_id     = '0;
   logic signed [31:0] old_x     = '0;
   logic signed [31:0] old_y     = '0;
   logic [30:0]        old_w     = '0;
   logic [30:0]        old_h     = '0;
   logic signed [31:0] aim_x     = '0;
   logic signed [31:0] aim_y     = '0;
   logic signed [31:0] step_x    = '0;
   logic signed [31:0] step_y    = '0;
   logic signed [31:0] lim_right = asc_pkg::POS_EXT;
   logic signed [31:0] lim_left  = asc_pkg::NEG_EXT;
   logic signed [31:0] lim_down  = asc_pkg::POS_EXT;
   logic signed [31:0] lim_up    = asc_pkg::NEG_EXT;
   logic               moving    = 1'b0;
   logic [15:0]        gap       = asc_pkg::MARGIN_RESET;

   asc_pkg::result_type owed_results[$];
   drow_type   plan[$];
   int         mismatches    = 0;
   int         sent_items    = 0;
   int         events_seen   = 0;
   int         finals_seen   = 0;
   int         burst_left    = 0;
   logic       idle_on       = 1'b1;
   int         hold_requests = 0;
   int         hold_served   = 0;
   int         hold_left     = 0;
   logic [15:0] margin_a, margin_b;

   aabb_slide_collision dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   always #10 clock = ~clock;

   // run limit
   initial begin
      #4_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic asc_pkg::item_type box_item(input logic cmd, input logic [15:0] id,
                                         input logic signed [31:0] x, y,
                                         input logic [30:0] w, h,
                                         input logic signed [31:0] dx, dy,
                                         input logic mot, last);
      asc_pkg::item_type it;
      it.cmd = cmd;       it.ent_id = id;
      it.box_x = x;       it.box_y = y;
      it.box_w = w;       it.box_h = h;
      it.move_dx = dx;    it.move_dy = dy;
      it.has_motion = mot;
      it.last_box = last;
      return it;
   endfunction

   function automatic asc_pkg::result_type mk_event(input logic [15:0] mover, other,
                                           input logic signed [1:0] nx, ny,
                                           input logic ends);
      asc_pkg::result_type r;
      r = '0;
      r.out_kind = asc_pkg::KIND_EVENT;
      r.mover_id = mover;
      r.other_id = other;
      r.normal_x = nx;
      r.normal_y = ny;
      r.run_end  = ends;
      return r;
   endfunction

   function automatic asc_pkg::result_type mk_final(input logic [15:0] mover,
                                           input logic signed [31:0] x, y,
                                           input logic fall);
      asc_pkg::result_type r;
      r = '0;
      r.out_kind   = asc_pkg::KIND_FINAL;
      r.mover_id   = mover;
      r.new_x      = x;
      r.new_y      = y;
      r.fall_start = fall;
      r.run_end    = 1'b1;
      return r;
   endfunction

   function automatic logic signed [31:0] clip32(input longint v);
      if (v > longint'(asc_pkg::POS_EXT)) return asc_pkg::POS_EXT;
      if (v < longint'(asc_pkg::NEG_EXT)) return asc_pkg::NEG_EXT;
      return v[31:0];
   endfunction

   function automatic void open_bounds();
      lim_right = asc_pkg::POS_EXT;
      lim_left  = asc_pkg::NEG_EXT;
      lim_down  = asc_pkg::POS_EXT;
      lim_up    = asc_pkg::NEG_EXT;
   endfunction

   // applied move: wanted position clamped to the bounds, margin kept off real ones
   function automatic asc_pkg::result_type resolve_position();
      longint m, nx, ny, lim;
      logic   fall;
      m  = longint'(gap);
      nx = old_x;
      ny = old_y;
      if (step_x > 0) begin
         lim = (lim_right == asc_pkg::POS_EXT) ? asc_pkg::POS_EXT : clip32(lim_right - m);
         nx  = (aim_x < lim) ? aim_x : lim;
      end else if (step_x < 0) begin
         lim = (lim_left == asc_pkg::NEG_EXT) ? asc_pkg::NEG_EXT : clip32(lim_left + m);
         nx  = (aim_x > lim) ? aim_x : lim;
      end
      if (step_y > 0) begin
         lim = (lim_down == asc_pkg::POS_EXT) ? asc_pkg::POS_EXT : clip32(lim_down - m);
         ny  = (aim_y < lim) ? aim_y : lim;
      end else if (step_y < 0) begin
         lim = (lim_up == asc_pkg::NEG_EXT) ? asc_pkg::NEG_EXT : clip32(lim_up + m);
         ny  = (aim_y > lim) ? aim_y : lim;
      end
      fall = moving && (step_y > 0) && ((ny - old_y) > m);
      return mk_final(mv_id, nx[31:0], ny[31:0], fall);
   endfunction

   // one accepted word: update slide state, return the results it causes
   function automatic int slide_step(input asc_pkg::item_type it,
                                     output asc_pkg::result_type r0,
                                     output asc_pkg::result_type r1);
      longint bx, by, bw, bh, w, h, ax, ay;
      logic   ovx, ovy;
      logic signed [1:0] nx, ny;
      int     n;
      n  = 0;
      r0 = '0;
      r1 = '0;
      if (it.cmd == asc_pkg::CMD_BEGIN) begin
         mv_id  = it.ent_id;
         old_x  = it.box_x;
         old_y  = it.box_y;
         old_w  = it.box_w;
         old_h  = it.box_h;
         step_x = it.move_dx;
         step_y = it.move_dy;
         aim_x  = clip32(longint'(it.box_x) + longint'(it.move_dx));
         aim_y  = clip32(longint'(it.box_y) + longint'(it.move_dy));
         moving = it.has_motion;
         open_bounds();
         if (it.last_box) begin
            r0 = resolve_position();
            n  = 1;
         end
         return n;
      end
      // other box, skipped when it carries the mover's id
      if (it.ent_id != mv_id) begin
         bx = it.box_x;
         by = it.box_y;
         bw = longint'(it.box_w);
         bh = longint'(it.box_h);
         w  = longint'(old_w);
         h  = longint'(old_h);
         ax = aim_x;
         ay = aim_y;
         ovx = (ax < bx && ax + w > bx) || (bx < ax && bx + bw > ax);
         ovy = (ay < by && ay + h > by) || (by < ay && by + bh > ay);
         if (ovx && ovy) begin
            // crossing tests against the old box, above as fallback
            nx = asc_pkg::NRM_ZERO;
            ny = asc_pkg::NRM_NEG;
            if (old_x + w < bx && ax + w >= bx) begin
               nx = asc_pkg::NRM_NEG;  ny = asc_pkg::NRM_ZERO;
            end else if (old_y + h < by && ay + h >= by) begin
               nx = asc_pkg::NRM_ZERO; ny = asc_pkg::NRM_NEG;
            end else if (old_x > bx + bw && ax <= bx + bw) begin
               nx = asc_pkg::NRM_POS;  ny = asc_pkg::NRM_ZERO;
            end else if (old_y > by + bh && ay <= by + bh) begin
               nx = asc_pkg::NRM_ZERO; ny = asc_pkg::NRM_POS;
            end
            // bounds only ever tighten
            if (nx == asc_pkg::NRM_NEG && clip32(bx - w) < lim_right)
               lim_right = clip32(bx - w);
            if (nx == asc_pkg::NRM_POS && clip32(bx + bw) > lim_left)
               lim_left = clip32(bx + bw);
            if (ny == asc_pkg::NRM_NEG && clip32(by - h) < lim_down)
               lim_down = clip32(by - h);
            if (ny == asc_pkg::NRM_POS && clip32(by + bh) > lim_up)
               lim_up = clip32(by + bh);
            r0 = mk_event(mv_id, it.ent_id, nx, ny, !it.last_box);
            n  = 1;
         end
      end
      if (it.last_box) begin
         if (n == 0) r0 = resolve_position();
         else r1 = resolve_position();
         n++;
      end
      return n;
   endfunction

   function automatic logic same_result(input asc_pkg::result_type a, b);
      return (a.out_kind === b.out_kind) && (a.mover_id === b.mover_id) &&
             (a.other_id === b.other_id) && (a.normal_x === b.normal_x) &&
             (a.normal_y === b.normal_y) && (a.new_x === b.new_x) &&
             (a.new_y === b.new_y) && (a.fall_start === b.fall_start) &&
             (a.run_end === b.run_end);
   endfunction

   function automatic void note_mismatch(input string why,
                                         input asc_pkg::result_type want, got);
      mismatches++;
      if (mismatches <= SHOWN_MAX) begin
         $display("mismatch (%s) at %0t", why, $time);
         $display("  expected kind %0d mover %h other %h normal %0d,%0d pos %h,%h fall %b end %b",
                  want.out_kind, want.mover_id, want.other_id, want.normal_x,
                  want.normal_y, want.new_x, want.new_y, want.fall_start, want.run_end);
         $display("  actual   kind %0d mover %h other %h normal %0d,%0d pos %h,%h fall %b end %b",
                  got.out_kind, got.mover_id, got.other_id, got.normal_x,
                  got.normal_y, got.new_x, got.new_y, got.fall_start, got.run_end);
      end
   endfunction

   function automatic int spread(input int span);
      return int'($urandom_range(2 * span)) - span;
   endfunction

   function automatic logic signed [31:0] pick_disp();
      int roll;
      roll = int'($urandom_range(99));
      if (roll < 20) return 0;
      if (roll < 92) return spread(700);
      return $urandom;
   endfunction

   // result side: random stalls, long hold-off on request
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on) begin
         rsp_tready <= ($urandom_range(99) >= 21);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin : watch_rsp
      asc_pkg::result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.out_kind   = rsp_tuser;
         got.mover_id   = rsp_tdata[15:0];
         got.other_id   = rsp_tdata[31:16];
         got.normal_x   = rsp_tdata[33:32];
         got.normal_y   = rsp_tdata[35:34];
         got.new_x      = rsp_tdata[67:36];
         got.new_y      = rsp_tdata[99:68];
         got.fall_start = rsp_tdata[100];
         got.run_end    = rsp_tlast;
         if (got.out_kind == asc_pkg::KIND_FINAL) finals_seen++;
         else events_seen++;
         if (owed_results.size() == 0) begin
            note_mismatch("word with nothing owed", '0, got);
         end else begin
            want = owed_results.pop_front();
            if (!same_result(want, got)) note_mismatch("wrong field", want, got);
         end
      end
   end

   // sender idling, skipped during a burst
   task automatic maybe_idle();
      if (burst_left > 0) begin
         burst_left--;
      end else if (idle_on) begin
         while ($urandom_range(99) < 21) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   // present one word and wait for it to be taken
   task automatic send_item(input asc_pkg::item_type it, output int n,
                            output asc_pkg::result_type r0,
                            output asc_pkg::result_type r1);
      // ent_id, box_x, box_y, box_w, box_h, move_dx, move_dy, has_motion, pad
      req_tdata  <= {1'b0, it.has_motion, it.move_dy, it.move_dx, it.box_h, it.box_w,
                     it.box_y, it.box_x, it.ent_id};
      req_tuser  <= it.cmd;
      req_tlast  <= it.last_box;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n = slide_step(it, r0, r1);
      sent_items++;
   endtask

   task automatic offer(input asc_pkg::item_type it);
      int n;
      asc_pkg::result_type r0, r1;
      maybe_idle();
      send_item(it, n, r0, r1);
      if (n > 0) owed_results.push_back(r0);
      if (n > 1) owed_results.push_back(r1);
   endtask

   // pause input until every owed result is in, then let in-flight work finish
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_margin(input logic [15:0] v);
      csr_data  <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      gap = v;
      csr_valid <= 1'b0;
   endtask

   // random slides: begin, boxes near the wanted box, last mark; some noise words
   task automatic run_slides(input int count);
      int stop_at, boxes;
      logic lone;
      logic [15:0] who;
      logic signed [31:0] base_x, base_y, mx, my, dx, dy;
      logic [30:0] mw, mh;
      stop_at = sent_items + count;
      while (sent_items < stop_at) begin
         if ($urandom_range(99) < 12) begin
            offer(box_item(1'($urandom_range(1)), 16'($urandom), $urandom, $urandom,
                           31'($urandom), 31'($urandom), $urandom, $urandom,
                           1'($urandom_range(1)), 1'($urandom_range(1))));
         end else begin
            base_x = ($urandom_range(3) == 0) ? $urandom : 0;
            base_y = ($urandom_range(3) == 0) ? $urandom : 0;
            mx     = base_x + spread(3000);
            my     = base_y + spread(3000);
            mw     = ($urandom_range(19) == 0) ? 31'($urandom) : 31'($urandom_range(400));
            mh     = ($urandom_range(19) == 0) ? 31'($urandom) : 31'($urandom_range(400));
            dx     = pick_disp();
            dy     = pick_disp();
            who    = 16'($urandom);
            lone   = ($urandom_range(19) == 0);
            boxes  = int'($urandom_range(1, 8));
            offer(box_item(asc_pkg::CMD_BEGIN, who, mx, my, mw, mh, dx, dy,
                           1'($urandom_range(1)), lone));
            if (!lone) begin
               for (int k = 1; k <= boxes; k++) begin
                  offer(box_item(asc_pkg::CMD_BOX,
                                 ($urandom_range(9) == 0) ? who : 16'($urandom),
                                 mx + (dx >>> 1) + spread(600), my + (dy >>> 1) + spread(600),
                                 31'($urandom_range(400)), 31'($urandom_range(400)),
                                 $urandom, $urandom, 1'($urandom_range(1)), k == boxes));
               end
            end
         end
      end
   endtask

   initial begin
      int n;
      asc_pkg::result_type r0, r1;

      // directed rows, margin at its reset value
      plan.push_back('{box_item(asc_pkg::CMD_BOX, 16'd5, -100, -100, 200, 200, 0, 0,
                                1'b0, 1'b1), 2,
                       mk_event(16'd0, 16'd5, asc_pkg::NRM_ZERO, asc_pkg::NRM_NEG, 1'b0),
                       mk_final(16'd0, 0, 0, 1'b0)});
      plan.push_back('{box_item(asc_pkg::CMD_BEGIN, 16'd7, 1000, 2000, 50, 60, 0, 0,
                                1'b0, 1'b1), 1,
                       mk_final(16'd7, 1000, 2000, 1'b0), '0});
      plan.push_back('{box_item(asc_pkg::CMD_BEGIN, 16'hFFFF, 32'h7FFF_0000, -5, 0, 0,
                                32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1), 1,
                       mk_final(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0), '0});
      plan.push_back('{box_item(asc_pkg::CMD_BEGIN, 16'd50, -5, 32'h7FFF_0000, 10, 10,
                                32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1), 1,
                       mk_final(16'd50, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1), '0});
      plan.push_back('{box_item(asc_pkg::CMD_BEGIN, 16'd9, 0, 0, 100, 100, 0, 100000,
                                1'b1, 1'b1), 1,
                       mk_final(16'd9, 0, 100000, 1'b1), '0});
      plan.push_back('{box_item(asc_pkg::CMD_BEGIN, 16'd9, 0, 0, 100, 100, 0, 100000,
                                1'b0, 1'b1), 1,
                       mk_final(16'd9, 0, 100000, 1'b0), '0});
      plan.push_back('{box_item(asc_pkg::CMD_BEGIN, 16'd7, 0, 0, 100, 100, 500, 0,
                                1'b0, 1'b0), 0,
                       '0, '0});
      // own id skipped, last mark still resolves
      plan.push_back('{box_item(asc_pkg::CMD_BOX, 16'd7, 0, 0, 100, 100, 0, 0, 1'b0, 1'b1), 1,
                       mk_final(16'd7, 500, 0, 1'b0), '0});
      plan.push_back('{box_item(asc_pkg::CMD_BOX, 16'd20, 550, 10, 100, 100, 0, 0,
                                1'b0, 1'b0), MODEL_CHECKED, '0, '0});
      plan.push_back('{box_item(asc_pkg::CMD_BOX, 16'd0, 480, -90, 40, 95, 0, 0,
                                1'b0, 1'b0), MODEL_CHECKED, '0, '0});
      plan.push_back('{box_item(asc_pkg::CMD_BOX, 16'd21, 10000, 0, 10, 10, 0, 0,
                                1'b0, 1'b1), MODEL_CHECKED, '0, '0});
      plan.push_back('{box_item(asc_pkg::CMD_BOX, 16'd22, 520, 20, 0, 0, 0, 0,
                                1'b0, 1'b1), MODEL_CHECKED, '0, '0});
      plan.push_back('{box_item(asc_pkg::CMD_BEGIN, 16'd30, 0, 0, 100, 100, 0, 1000,
                                1'b1, 1'b0), MODEL_CHECKED, '0, '0});
      plan.push_back('{box_item(asc_pkg::CMD_BOX, 16'd31, 10, 1050, 50, 200, 0, 0,
                                1'b0, 1'b1), MODEL_CHECKED, '0, '0});
      plan.push_back('{box_item(asc_pkg::CMD_BEGIN, 16'd40, 1000, 1000, 100, 100, -600, -600,
                                1'b1, 1'b0), MODEL_CHECKED, '0, '0});
      plan.push_back('{box_item(asc_pkg::CMD_BOX, 16'd41, 350, 350, 100, 200, 0, 0,
                                1'b0, 1'b0), MODEL_CHECKED, '0, '0});
      plan.push_back('{box_item(asc_pkg::CMD_BOX, 16'd42, 32'h8000_0000, 32'h8000_0000,
                                31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                1'b1, 1'b0), MODEL_CHECKED, '0, '0});
      plan.push_back('{box_item(asc_pkg::CMD_BOX, 16'd43, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0,
                                0, 0, 1'b0, 1'b1), MODEL_CHECKED, '0, '0});
      plan.push_back('{box_item(asc_pkg::CMD_BOX, 16'd44, 380, 380, 10, 10, 0, 0,
                                1'b0, 1'b1), MODEL_CHECKED, '0, '0});
      plan.push_back('{box_item(asc_pkg::CMD_BOX, 16'hFFFF, 0, 0, 1, 1, 0, 0,
                                1'b0, 1'b0), MODEL_CHECKED, '0, '0});

      margin_a = 16'($urandom_range(1, 65534));
      margin_b = 16'($urandom_range(1, 65534));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part
      foreach (plan[i]) begin
         if (plan[i].known == MODEL_CHECKED) begin
            offer(plan[i].stim);
         end else begin
            maybe_idle();
            send_item(plan[i].stim, n, r0, r1);
            if (plan[i].known > 0) owed_results.push_back(plan[i].ans0);
            if (plan[i].known > 1) owed_results.push_back(plan[i].ans1);
         end
      end
      run_slides(60);

      // zero margin, with a long result-side hold while words keep coming
      wait_drained();
      write_margin(16'd0);
      hold_requests <= hold_requests + 1;
      burst_left = 48;
      run_slides(110);

      // random margin, no idling on either side
      wait_drained();
      write_margin(margin_a);
      idle_on <= 1'b0;
      run_slides(110);

      // largest margin
      wait_drained();
      write_margin(16'hFFFF);
      idle_on <= 1'b1;
      run_slides(110);

      wait_drained();
      write_margin(margin_b);
      run_slides(110);

      wait_drained();
      mismatches += owed_results.size();
      $display("run covered %0d input words, %0d collision events, %0d final positions",
               sent_items, events_seen, finals_seen);
      $display("margins 33, 0, %0d, 65535, %0d; one long result hold and one gap-free phase",
               margin_a, margin_b);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
